### rtl/pcpr_pkg.sv
// ----------------------------------------------------------------------------
// pcpr_pkg
// Shared types and constants for the point cloud projection and rotation block.
// ----------------------------------------------------------------------------
package pcpr_pkg;

    localparam int TRIG_BITS  = 14;
    localparam int QBITS      = 15;
    localparam int DIV_STAGES = QBITS + 1;
    localparam int NUM_W      = 48;
    localparam int MAG_W      = NUM_W - 1;
    localparam int DEN_W      = 33;
    localparam int ACC_W      = 66;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_POINT = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_SINE   = 2'd2,
        CFG_COSINE = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_INSIDE  = 2'd0,
        ST_OUTSIDE = 2'd1,
        ST_ZERO_W  = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [31:0] wx;
        logic signed [31:0] wy;
        logic signed [31:0] wz;
        logic               zw;
    } side_t;

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] x);
        logic signed [ACC_W-1:0] lo;
        logic signed [ACC_W-1:0] hi;
        lo = -(ACC_W'(64'sd2147483648));
        hi = ACC_W'(64'sd2147483647);
        if (x < lo)
        begin
            return 32'sh8000_0000;
        end
        else if (x > hi)
        begin
            return 32'sh7fff_ffff;
        end
        return x[31:0];
    endfunction

endpackage

### rtl/pcpr_div.sv
// ----------------------------------------------------------------------------
// pcpr_div
// Pipelined signed-by-positive divider, one quotient bit per stage, with the
// quotient truncated towards zero and clamped to the 16-bit signed range.
// ----------------------------------------------------------------------------
module pcpr_div (
    input  logic                                 clk,
    input  logic [pcpr_pkg::DIV_STAGES-1:0]      en,
    input  logic signed [pcpr_pkg::NUM_W-1:0]    num,
    input  logic [pcpr_pkg::DEN_W-1:0]           den,
    output logic signed [15:0]                   quo
);
    import pcpr_pkg::*;

    logic [MAG_W-1:0] rem_reg [DIV_STAGES];
    logic [DEN_W-1:0] den_reg [DIV_STAGES];
    logic [QBITS-1:0] q_reg   [DIV_STAGES];
    logic             neg_reg [DIV_STAGES];
    logic             ovf_reg [DIV_STAGES];

    logic [MAG_W-1:0] mag_next;
    logic             ovf_next;

    // magnitude and overflow check: |num| >= den * 2^15
    always_comb
    begin
        mag_next = num[NUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
        ovf_next = NUM_W'({1'b0, mag_next}) >= (NUM_W'(den) << QBITS);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            rem_reg[0] <= mag_next;
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            neg_reg[0] <= num[NUM_W-1];
            ovf_reg[0] <= ovf_next;
        end
    end

    for (genvar i = 1; i < DIV_STAGES; i++)
    begin : g_bit
        logic [NUM_W-1:0] dsh;
        logic             take;
        logic [MAG_W-1:0] rem_next;
        logic [QBITS-1:0] q_next;

        always_comb
        begin
            dsh      = NUM_W'(den_reg[i-1]) << (QBITS - i);
            take     = NUM_W'({1'b0, rem_reg[i-1]}) >= dsh;
            rem_next = take ? MAG_W'(NUM_W'(rem_reg[i-1]) - dsh) : rem_reg[i-1];
            q_next   = q_reg[i-1];
            q_next[QBITS-i] = take;
        end

        always_ff @(posedge clk)
        begin
            if (en[i])
            begin
                rem_reg[i] <= rem_next;
                den_reg[i] <= den_reg[i-1];
                q_reg[i]   <= q_next;
                neg_reg[i] <= neg_reg[i-1];
                ovf_reg[i] <= ovf_reg[i-1];
            end
        end
    end

    logic [16:0] mag_fin;

    always_comb
    begin
        if (ovf_reg[DIV_STAGES-1])
        begin
            mag_fin = neg_reg[DIV_STAGES-1] ? 17'd32768 : 17'd32767;
        end
        else
        begin
            mag_fin = 17'(q_reg[DIV_STAGES-1]);
        end
        quo = neg_reg[DIV_STAGES-1] ? 16'(-mag_fin) : 16'(mag_fin);
    end

endmodule

### rtl/point_cloud_projection_rotation.sv
// ----------------------------------------------------------------------------
// point_cloud_projection_rotation
// Camera pose and screen projection of points, with yaw rotation of the
// world point. One point word can enter every cycle while the output is not
// stalled; a result word is presented once its point has passed stages 1 to 5,
// the divider stages and the output register. The divider produces one quotient
// bit per stage. Matrix load words produce no result and are held off while a
// point is still in the two stages before the screen matrix read.
// ----------------------------------------------------------------------------
module point_cloud_projection_rotation #(
    parameter int FRACTION_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               command,
    input  logic               matrix_select,
    input  logic [3:0]         entry_index,
    input  logic signed [31:0] entry_value,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] point_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] world_x,
    output logic signed [31:0] world_y,
    output logic signed [31:0] world_z,
    output logic signed [15:0] pixel_x,
    output logic signed [15:0] pixel_y,
    output logic [1:0]         status
);
    import pcpr_pkg::*;

    localparam int DIV_BASE = 5;
    localparam int NS       = DIV_BASE + DIV_STAGES + 1;
    localparam int OUT_STG  = NS - 1;

    // configuration
    logic [13:0]        width_reg;
    logic [13:0]        height_reg;
    logic signed [15:0] sine_reg;
    logic signed [15:0] cosine_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 14'd640;
            height_reg <= 14'd480;
            sine_reg   <= '0;
            cosine_reg <= 16'sd16384;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_WIDTH:  width_reg  <= cfg_data[13:0];
                CFG_HEIGHT: height_reg <= cfg_data[13:0];
                CFG_SINE:   sine_reg   <= cfg_data;
                CFG_COSINE: cosine_reg <= cfg_data;
            endcase
        end
    end

    // handshake and stage control
    logic [NS-1:0] vld_reg;
    logic [NS-1:0] vld_next;
    logic [NS-1:0] adv;
    logic          in_acc;
    logic          pt_acc;
    logic          ld_acc;

    always_comb
    begin
        adv[NS-1] = !vld_reg[NS-1] || out_ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    assign in_ready = (cmd_t'(command) == CMD_POINT) ? adv[0] : !(vld_reg[0] || vld_reg[1]);
    assign in_acc   = in_valid && in_ready;
    assign pt_acc   = in_acc && (cmd_t'(command) == CMD_POINT);
    assign ld_acc   = in_acc && (cmd_t'(command) == CMD_LOAD);

    always_comb
    begin
        vld_next[0] = adv[0] ? pt_acc : vld_reg[0];
        for (int k = 1; k < NS; k++)
        begin
            vld_next[k] = adv[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // matrix store: camera at 0..15, screen at 16..31
    logic signed [31:0] mat_reg [32];

    always_ff @(posedge clk)
    begin
        if (ld_acc)
        begin
            mat_reg[{matrix_select, entry_index}] <= entry_value;
        end
    end

    // stage 1: camera products
    logic signed [31:0] pnt [3];
    logic signed [63:0] s1_prod_next [3][3];
    logic signed [63:0] s1_prod_reg  [3][3];
    logic signed [31:0] s1_bias_reg  [3];

    assign pnt[0] = point_x;
    assign pnt[1] = point_y;
    assign pnt[2] = point_z;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                s1_prod_next[r][c] = 64'(mat_reg[r*4+c]) * 64'(pnt[c]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            s1_prod_reg <= s1_prod_next;
            for (int r = 0; r < 3; r++)
            begin
                s1_bias_reg[r] <= mat_reg[r*4+3];
            end
        end
    end

    // stage 2: world point
    logic signed [31:0] v_next [3];
    logic signed [31:0] v_reg  [3];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            v_next[r] = sat32(ACC_W'(s1_bias_reg[r])
                            + ACC_W'(s1_prod_reg[r][0] >>> FRACTION_BITS)
                            + ACC_W'(s1_prod_reg[r][1] >>> FRACTION_BITS)
                            + ACC_W'(s1_prod_reg[r][2] >>> FRACTION_BITS));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            v_reg <= v_next;
        end
    end

    // stage 3: screen products (rows x, y, w) and yaw products
    logic signed [63:0] s3_prod_next [3][3];
    logic signed [63:0] s3_prod_reg  [3][3];
    logic signed [31:0] s3_bias_reg  [3];
    logic signed [47:0] xs_reg;
    logic signed [47:0] zc_reg;
    logic signed [47:0] xc_reg;
    logic signed [47:0] zs_reg;
    logic signed [31:0] s3_wy_reg;

    function automatic int scr_row(input int j);
        return (j == 2) ? 3 : j;
    endfunction

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                s3_prod_next[j][c] = 64'(mat_reg[16 + scr_row(j)*4 + c]) * 64'(v_reg[c]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            s3_prod_reg <= s3_prod_next;
            for (int j = 0; j < 3; j++)
            begin
                s3_bias_reg[j] <= mat_reg[16 + scr_row(j)*4 + 3];
            end
            xs_reg    <= 48'(v_reg[0]) * 48'(sine_reg);
            zc_reg    <= 48'(v_reg[2]) * 48'(cosine_reg);
            xc_reg    <= 48'(v_reg[0]) * 48'(cosine_reg);
            zs_reg    <= 48'(v_reg[2]) * 48'(sine_reg);
            s3_wy_reg <= v_reg[1];
        end
    end

    // stage 4: clip point and rotated world point
    logic signed [31:0] t_next [3];
    logic signed [31:0] t_reg  [3];
    logic signed [48:0] rx_sum;
    logic signed [48:0] rz_sum;
    side_t              s4_side_next;
    side_t              s4_side_reg;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            t_next[j] = sat32(ACC_W'(s3_bias_reg[j])
                            + ACC_W'(s3_prod_reg[j][0] >>> FRACTION_BITS)
                            + ACC_W'(s3_prod_reg[j][1] >>> FRACTION_BITS)
                            + ACC_W'(s3_prod_reg[j][2] >>> FRACTION_BITS));
        end
        rx_sum = 49'(xs_reg) - 49'(zc_reg);
        rz_sum = 49'(xc_reg) + 49'(zs_reg);
        s4_side_next.wx = sat32(ACC_W'(rx_sum >>> TRIG_BITS));
        s4_side_next.wy = s3_wy_reg;
        s4_side_next.wz = sat32(ACC_W'(rz_sum >>> TRIG_BITS));
        s4_side_next.zw = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            t_reg       <= t_next;
            s4_side_reg <= s4_side_next;
        end
    end

    // stage 5: scaled numerators and denominator
    logic [31:0]             aw;
    logic signed [33:0]      tx_sum;
    logic signed [33:0]      ty_sum;
    logic signed [NUM_W-1:0] nx_reg;
    logic signed [NUM_W-1:0] ny_reg;
    logic [DEN_W-1:0]        den_reg;
    side_t                   s5_side_next;
    side_t                   s5_side_reg;

    always_comb
    begin
        aw     = t_reg[2][31] ? (~t_reg[2] + 32'd1) : t_reg[2];
        tx_sum = 34'(t_reg[0]) + $signed({2'b00, aw});
        ty_sum = 34'(t_reg[1]) + $signed({2'b00, aw});
        s5_side_next    = s4_side_reg;
        s5_side_next.zw = (t_reg[2] == 32'sd0);
    end

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            nx_reg      <= NUM_W'(tx_sum) * NUM_W'($signed({1'b0, width_reg}));
            ny_reg      <= NUM_W'(ty_sum) * NUM_W'($signed({1'b0, height_reg}));
            den_reg     <= {aw, 1'b0};
            s5_side_reg <= s5_side_next;
        end
    end

    // divider stages
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    side_t              side_reg [DIV_STAGES];

    pcpr_div u_div_x (
        .clk (clk),
        .en  (adv[DIV_BASE +: DIV_STAGES]),
        .num (nx_reg),
        .den (den_reg),
        .quo (qx)
    );

    pcpr_div u_div_y (
        .clk (clk),
        .en  (adv[DIV_BASE +: DIV_STAGES]),
        .num (ny_reg),
        .den (den_reg),
        .quo (qy)
    );

    always_ff @(posedge clk)
    begin
        if (adv[DIV_BASE])
        begin
            side_reg[0] <= s5_side_reg;
        end
        for (int j = 1; j < DIV_STAGES; j++)
        begin
            if (adv[DIV_BASE + j])
            begin
                side_reg[j] <= side_reg[j-1];
            end
        end
    end

    // output word
    side_t              fin_side;
    logic               in_image;
    status_t            status_next;
    logic signed [15:0] px_next;
    logic signed [15:0] py_next;
    logic signed [31:0] wx_reg;
    logic signed [31:0] wy_reg;
    logic signed [31:0] wz_reg;
    logic signed [15:0] px_reg;
    logic signed [15:0] py_reg;
    status_t            status_reg;

    always_comb
    begin
        fin_side = side_reg[DIV_STAGES-1];
        in_image = !qx[15] && (16'(qx) < 16'(width_reg))
                && !qy[15] && (16'(qy) < 16'(height_reg));
        if (fin_side.zw)
        begin
            status_next = ST_ZERO_W;
            px_next     = '0;
            py_next     = '0;
        end
        else
        begin
            status_next = in_image ? ST_INSIDE : ST_OUTSIDE;
            px_next     = qx;
            py_next     = qy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[OUT_STG])
        begin
            wx_reg     <= fin_side.wx;
            wy_reg     <= fin_side.wy;
            wz_reg     <= fin_side.wz;
            px_reg     <= px_next;
            py_reg     <= py_next;
            status_reg <= status_next;
        end
    end

    assign out_valid = vld_reg[OUT_STG];
    assign world_x   = wx_reg;
    assign world_y   = wy_reg;
    assign world_z   = wz_reg;
    assign pixel_x   = px_reg;
    assign pixel_y   = py_reg;
    assign status    = 2'(status_reg);

`ifndef ASSERT_OFF
    a_load_clear: assert property (@(posedge clk) disable iff (!rst_n)
        ld_acc |-> !vld_reg[0] && !vld_reg[1])
        else $error("matrix load taken with a point before the screen read");

    a_zero_w_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status_reg == ST_ZERO_W |-> pixel_x == 16'sd0 && pixel_y == 16'sd0)
        else $error("zero w word carries a pixel");

    a_inside_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status_reg == ST_INSIDE |-> !pixel_x[15] && !pixel_y[15])
        else $error("inside word with negative pixel");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[OUT_STG] && !out_ready |=> vld_reg[OUT_STG])
        else $error("output word lost while stalled");
`endif

endmodule
